// ===== hw/rtl/pca_waveform_feature_projection_assert.svh =====
// Assertion macros shared by the checker of the feature projection block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef PCA_WAVEFORM_FEATURE_PROJECTION_ASSERT_SVH
`define PCA_WAVEFORM_FEATURE_PROJECTION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pwfp_pkg.sv =====
// Shared sizes, codes and beat types of the feature projection block.
// No dependencies; every module file imports it.
package pwfp_pkg;

  localparam int CHANNELS   = 4;
  localparam int WINDOW     = 32;
  localparam int COMPONENTS = 3;
  localparam int SAMPLES    = 64;

  // field widths fixed by the interface
  localparam int CH_W   = 2;
  localparam int POS_W  = 6;
  localparam int COMP_W = 2;
  localparam int TV_W   = 24;
  localparam int SMP_W  = 16;
  localparam int FEAT_W = 32;
  localparam int FIDX_W = 4;

  // datapath widths
  localparam int MEAN_W = 24;
  localparam int COEF_W = 16;
  localparam int X_W    = 25;
  localparam int PROD_W = X_W + COEF_W;
  localparam int ACC_W  = 48;
  localparam int RND_SH = 23;

  localparam int TBL_DEPTH = CHANNELS * WINDOW;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CHN_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_AW    = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int NCH_W     = $clog2(CHANNELS + 1);
  localparam int NCMP_W    = $clog2(COMPONENTS + 1);
  localparam int WLEN_W    = $clog2(WINDOW + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTERED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPONENTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd4;

  // input actions
  localparam logic [1:0] ACT_MEAN   = 2'd0;
  localparam logic [1:0] ACT_COEF   = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic [CH_W-1:0]          channel;
    logic [POS_W-1:0]         position;
    logic [COMP_W-1:0]        component;
    logic signed [TV_W-1:0]   table_value;
    logic signed [SMP_W-1:0]  sample;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] feature;
    logic [FIDX_W-1:0]        feature_index;
    logic                     run_end;
  } out_item_t;

  // control of one sample travelling down the MAC pipeline
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [CHN_AW-1:0] ch;
    logic              last;
  } smp_ctl_t;

  typedef logic [ACC_W-1:0] acc_t;

endpackage

// ===== hw/rtl/pwfp_tables.sv =====
// Mean and coefficient tables: one mean bank and one coefficient bank per component.
// Depends on pwfp_pkg.
module pwfp_tables (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [pwfp_pkg::TBL_AW-1:0]          rd_addr,
  input  logic                                 mean_we,
  input  logic [pwfp_pkg::COMPONENTS-1:0]      coef_we,
  input  logic [pwfp_pkg::TBL_AW-1:0]          wr_addr,
  input  logic signed [pwfp_pkg::TV_W-1:0]     wr_value,
  output logic signed [pwfp_pkg::MEAN_W-1:0]   mean_q,
  output logic signed [pwfp_pkg::COEF_W-1:0]   coef_q [pwfp_pkg::COMPONENTS]
);
  import pwfp_pkg::*;

  logic signed [MEAN_W-1:0] mean_mem [TBL_DEPTH];
  logic signed [COEF_W-1:0] coef_mem [COMPONENTS][TBL_DEPTH];
  logic signed [COEF_W-1:0] coef_sat;

  // coefficients wider than Q1.15 clip at the rails
  always_comb begin
    if (wr_value > TV_W'(32'sd32767)) begin
      coef_sat = 16'sh7fff;
    end else if (wr_value < TV_W'(-32'sd32768)) begin
      coef_sat = 16'sh8000;
    end else begin
      coef_sat = COEF_W'(wr_value);
    end
  end

  always_ff @(posedge clk) begin
    if (mean_we) begin
      mean_mem[wr_addr] <= MEAN_W'(wr_value);
    end
    if (rd_en) begin
      mean_q <= mean_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < COMPONENTS; k++) begin
      if (coef_we[k]) begin
        coef_mem[k][wr_addr] <= coef_sat;
      end
      if (rd_en) begin
        coef_q[k] <= coef_mem[k][rd_addr];
      end
    end
  end

endmodule

// ===== hw/rtl/pwfp_mac.sv =====
// Centring, per-component multiply and accumulator bank of the projection.
// Depends on pwfp_pkg; table read data arrives from pwfp_tables.
module pwfp_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  pwfp_pkg::smp_ctl_t                  s0_ctl,
  input  logic signed [pwfp_pkg::SMP_W-1:0]   s0_smp,
  input  logic                                centered,
  input  logic [pwfp_pkg::NCMP_W-1:0]         ncomp,
  input  logic signed [pwfp_pkg::MEAN_W-1:0]  mean_q,
  input  logic signed [pwfp_pkg::COEF_W-1:0]  coef_q [pwfp_pkg::COMPONENTS],
  output logic                                pend_last,
  output logic                                snap_load,
  output pwfp_pkg::acc_t                      snap [pwfp_pkg::CHANNELS][pwfp_pkg::COMPONENTS]
);
  import pwfp_pkg::*;

  smp_ctl_t                 s1_ctl_r;
  logic signed [SMP_W-1:0]  s1_smp_r;
  smp_ctl_t                 s2_ctl_r;
  logic signed [PROD_W-1:0] s2_prod_r [COMPONENTS];
  acc_t                     acc_r [CHANNELS][COMPONENTS];

  logic signed [X_W-1:0]    x;
  logic signed [X_W-1:0]    mean_sub;
  logic signed [PROD_W-1:0] prod [COMPONENTS];
  acc_t                     sum [COMPONENTS];
  acc_t                     acc_new [CHANNELS][COMPONENTS];
  logic                     fire;

  // stage 1: sample in Q.8, minus the stored mean when centered, times each coefficient
  always_comb begin
    mean_sub = centered ? X_W'(mean_q) : X_W'(0);
    x        = (X_W'(s1_smp_r) <<< 8) - mean_sub;
    for (int k = 0; k < COMPONENTS; k++) begin
      prod[k] = PROD_W'(x) * PROD_W'(coef_q[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= s0_ctl;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_smp_r <= s0_smp;
      for (int k = 0; k < COMPONENTS; k++) begin
        s2_prod_r[k] <= prod[k];
      end
    end
  end

  // stage 2: one adder per component, on the row picked by the channel
  always_comb begin
    for (int k = 0; k < COMPONENTS; k++) begin
      sum[k] = acc_r[s2_ctl_r.ch][k] + ACC_W'(s2_prod_r[k]);
    end
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < COMPONENTS; k++) begin
        if (s2_ctl_r.valid && s2_ctl_r.hit && 32'(s2_ctl_r.ch) == c &&
            k < 32'(ncomp)) begin
          acc_new[c][k] = sum[k];
        end else begin
          acc_new[c][k] = acc_r[c][k];
        end
      end
    end
  end

  assign pend_last = s2_ctl_r.valid && s2_ctl_r.last;
  assign fire      = adv && pend_last;
  assign snap_load = fire;
  assign snap      = acc_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < COMPONENTS; k++) begin
          acc_r[c][k] <= '0;
        end
      end
    end else if (adv) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < COMPONENTS; k++) begin
          acc_r[c][k] <= fire ? '0 : acc_new[c][k];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/pwfp_drain.sv =====
// Snapshot buffer of finished accumulators, rounding and the output register.
// Depends on pwfp_pkg; snapshots arrive from pwfp_mac.
module pwfp_drain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          snap_load,
  input  pwfp_pkg::acc_t                snap [pwfp_pkg::CHANNELS][pwfp_pkg::COMPONENTS],
  input  logic [pwfp_pkg::NCH_W-1:0]    nch,
  input  logic [pwfp_pkg::NCMP_W-1:0]   ncomp,
  input  logic                          out_stall,
  output logic                          busy,
  output logic                          out_valid,
  output pwfp_pkg::out_item_t           out_data
);
  import pwfp_pkg::*;

  localparam int RND_W = ACC_W + 1 - RND_SH;

  acc_t              snap_r [CHANNELS][COMPONENTS];
  logic              busy_r;
  logic [CHN_AW-1:0] c_r;
  logic [CMP_AW-1:0] k_r;
  logic [FIDX_W-1:0] idx_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              out_free;
  logic              step;
  logic              k_end;
  logic              c_end;
  acc_t              cur;
  acc_t              mag;
  logic [ACC_W:0]    mag_rnd;
  logic [FEAT_W-1:0] feat_mag;
  out_item_t         beat;

  // |acc| < 2^47 scaled by 2^-23 stays below 2^25, so the 32-bit clip never bites
  always_comb begin
    cur      = snap_r[c_r][k_r];
    mag      = cur[ACC_W-1] ? (~cur + ACC_W'(1)) : cur;
    mag_rnd  = {1'b0, mag} + (ACC_W + 1)'(1 << (RND_SH - 1));
    feat_mag = FEAT_W'(mag_rnd[ACC_W:RND_SH]);
    k_end    = (32'(k_r) + 1) == 32'(ncomp);
    c_end    = (32'(c_r) + 1) == 32'(nch);
    beat.feature       = cur[ACC_W-1] ? -feat_mag : feat_mag;
    beat.feature_index = idx_r;
    beat.run_end       = k_end && c_end;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign step     = busy_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      c_r         <= '0;
      k_r         <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (snap_load) begin
        busy_r <= 1'b1;
        c_r    <= '0;
        k_r    <= '0;
        idx_r  <= '0;
      end else if (step) begin
        idx_r <= idx_r + FIDX_W'(1);
        if (k_end) begin
          k_r <= '0;
          if (c_end) begin
            busy_r <= 1'b0;
          end else begin
            c_r <= c_r + CHN_AW'(1);
          end
        end else begin
          k_r <= k_r + CMP_AW'(1);
        end
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_r <= snap;
    end
    if (step) begin
      out_data_r <= beat;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/pca_waveform_feature_projection.sv =====
// Top level of the spike waveform PCA feature projection block.
// Depends on pwfp_pkg, pwfp_tables, pwfp_mac and pwfp_drain.
//
// Projects multichannel spike samples onto per-channel principal components.
// Load beats (action 0/1) fill the Q16.8 mean table and the Q1.15 coefficient
// table, addressed by channel and window offset; out-of-range loads are dropped,
// coefficients clip to 16 bits. A sample beat (action 2) inside the window of
// an enabled channel is widened to Q.8, optionally mean-subtracted, multiplied
// by each used component's coefficient and added into a 48-bit accumulator
// that wraps. A sample beat with last set dumps channels_used x components_used
// feature beats (accumulator / 2^23, rounded half away from zero, saturated to
// 32 bits) in channel-major order, then clears the accumulators.
// Rate: one input beat per clock while in_stall is low, loads and samples
// alike. Samples pass through a three-register pipe: table read, multiply,
// accumulate. Once the closing sample reaches the accumulate stage, the
// waveform's snapshot drains at one feature beat per cycle while the next
// one comes in, unless the output stalls. Input stall rises only while a second
// waveform end sits in the accumulate stage and the previous snapshot is
// still draining. Tables are not cleared by reset; read only loaded entries.
// Config is taken by cfg_we/cfg_index/cfg_wdata and must only change when idle.
// Count registers are clamped: window length to 1..WINDOW, components and
// channels to 1..their maximum.
module pca_waveform_feature_projection (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pwfp_pkg::in_item_t                 in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output pwfp_pkg::out_item_t                out_data,
  // configuration
  input  logic                               cfg_we,
  input  logic [pwfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwfp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pwfp_pkg::*;

  // configuration registers, raw as written
  logic        centered_r;
  logic [5:0]  win_start_r;
  logic [5:0]  win_len_r;
  logic [1:0]  ncomp_raw_r;
  logic [2:0]  nch_raw_r;

  // clamped counts
  logic [WLEN_W-1:0] wlen;
  logic [NCMP_W-1:0] ncomp;
  logic [NCH_W-1:0]  nch;

  // front end decode
  logic              accept;
  logic              adv;
  logic [POS_W-1:0]  off;
  logic              in_win;
  logic              hit;
  logic              tbl_ok;
  logic [TBL_AW-1:0] rd_addr;
  logic [TBL_AW-1:0] wr_addr;
  logic              mean_we;
  logic [COMPONENTS-1:0] coef_we;
  smp_ctl_t          s0_ctl;

  // between units
  logic signed [MEAN_W-1:0] mean_q;
  logic signed [COEF_W-1:0] coef_q [COMPONENTS];
  logic                     pend_last;
  logic                     snap_load;
  acc_t                     snap [CHANNELS][COMPONENTS];
  logic                     busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centered_r  <= 1'b0;
      win_start_r <= 6'd0;
      win_len_r   <= 6'd32;
      ncomp_raw_r <= 2'd3;
      nch_raw_r   <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTERED:   centered_r  <= cfg_wdata[0];
        CFG_WIN_START:  win_start_r <= cfg_wdata[5:0];
        CFG_WIN_LENGTH: win_len_r   <= cfg_wdata[5:0];
        CFG_COMPONENTS: ncomp_raw_r <= cfg_wdata[1:0];
        CFG_CHANNELS:   nch_raw_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (win_len_r == '0) begin
      wlen = WLEN_W'(1);
    end else if (32'(win_len_r) > WINDOW) begin
      wlen = WLEN_W'(WINDOW);
    end else begin
      wlen = WLEN_W'(win_len_r);
    end
    if (ncomp_raw_r == '0) begin
      ncomp = NCMP_W'(1);
    end else if (32'(ncomp_raw_r) > COMPONENTS) begin
      ncomp = NCMP_W'(COMPONENTS);
    end else begin
      ncomp = NCMP_W'(ncomp_raw_r);
    end
    if (nch_raw_r == '0) begin
      nch = NCH_W'(1);
    end else if (32'(nch_raw_r) > CHANNELS) begin
      nch = NCH_W'(CHANNELS);
    end else begin
      nch = NCH_W'(nch_raw_r);
    end
  end

  // the pipe only holds when a waveform end cannot hand its snapshot over
  assign adv      = !(pend_last && busy);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_comb begin
    off    = in_data.position - win_start_r;
    in_win = (in_data.position >= win_start_r) && (32'(off) < 32'(wlen));
    hit    = (32'(in_data.position) < SAMPLES) && in_win &&
             (32'(in_data.channel) < 32'(nch));
    tbl_ok = (32'(in_data.channel) < CHANNELS) && (32'(in_data.position) < WINDOW);

    rd_addr = TBL_AW'(32'(in_data.channel) * WINDOW + 32'(off));
    wr_addr = TBL_AW'(32'(in_data.channel) * WINDOW + 32'(in_data.position));

    mean_we = accept && (in_data.action == ACT_MEAN) && tbl_ok;
    for (int k = 0; k < COMPONENTS; k++) begin
      coef_we[k] = accept && (in_data.action == ACT_COEF) && tbl_ok &&
                   (32'(in_data.component) == k);
    end

    s0_ctl.valid = accept && (in_data.action == ACT_SAMPLE);
    s0_ctl.hit   = hit;
    s0_ctl.ch    = CHN_AW'(in_data.channel);
    s0_ctl.last  = in_data.last;
  end

  pwfp_tables u_tables (
    .clk      (clk),
    .rd_en    (adv),
    .rd_addr  (rd_addr),
    .mean_we  (mean_we),
    .coef_we  (coef_we),
    .wr_addr  (wr_addr),
    .wr_value (in_data.table_value),
    .mean_q   (mean_q),
    .coef_q   (coef_q)
  );

  pwfp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s0_ctl    (s0_ctl),
    .s0_smp    (in_data.sample),
    .centered  (centered_r),
    .ncomp     (ncomp),
    .mean_q    (mean_q),
    .coef_q    (coef_q),
    .pend_last (pend_last),
    .snap_load (snap_load),
    .snap      (snap)
  );

  pwfp_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_load (snap_load),
    .snap      (snap),
    .nch       (nch),
    .ncomp     (ncomp),
    .out_stall (out_stall),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/pwfp_checker.sv =====
// Port-level checker of the feature projection block, bound to the top level.
// Depends on pwfp_pkg and pca_waveform_feature_projection_assert.svh.
`include "pca_waveform_feature_projection_assert.svh"

module pwfp_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  pwfp_pkg::out_item_t  out_data
);
  import pwfp_pkg::*;

  // a stalled result beat stays put
  `PWFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed while stalled")

  // a 48-bit accumulator scaled by 2^-23 cannot leave +/-2^24
  `PWFP_ASSERT_NOW(a_feat_range, out_valid, out_data.feature[31:25] == 7'h00 || out_data.feature[31:25] == 7'h7f, "feature outside accumulator range")

  // features of one spike come back to back with rising index
  `PWFP_ASSERT_NEXT(a_idx_step, out_valid && !out_stall && !out_data.run_end, out_valid && out_data.feature_index == FIDX_W'($past(out_data.feature_index) + 1), "feature index did not step")

  // a new spike starts at index zero
  `PWFP_ASSERT_NEXT(a_idx_restart, out_valid && !out_stall && out_data.run_end, !out_valid || out_data.feature_index == '0, "spike did not restart at index zero")

endmodule

bind pca_waveform_feature_projection pwfp_checker u_pwfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/testbench.sv =====
// Self-checking bench for the spike waveform PCA feature projection block.
// Depends on pwfp_pkg and the RTL of pca_waveform_feature_projection; nothing else.
// A predictor mirrors the tables and accumulators and checks every feature beat.
module testbench;
  import pwfp_pkg::*;

  // Action code 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int CLK_PERIOD    = 8;
  localparam int RST_CYCLES    = 6;
  localparam int QUIET_CYCLES  = 8;   // pipe is three deep
  localparam int TAIL_CYCLES   = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_SAMPLES = 25;
  localparam int PRESSURE_RUNS = 30;
  localparam int WRAP_SAMPLES  = 300;
  localparam longint HALF_LSB  = 64'sd1 <<< (RND_SH - 1);

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  // One line of the directed plan: either a beat or a register write.
  // zero_feat marks a beat whose features are all known to be zero.
  typedef struct {
    row_kind_e                 kind;
    in_item_t                  beat;
    logic [CFG_IDX_W-1:0]      ridx;
    logic [CFG_DATA_W-1:0]     rval;
    bit                        zero_feat;
  } row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: tables, accumulators and a shadow of the registers.
  logic signed [MEAN_W-1:0] mean_mem [TBL_DEPTH];
  logic signed [COEF_W-1:0] coef_mem [CHANNELS*COMPONENTS*WINDOW];
  logic signed [ACC_W-1:0]  proj_acc [CHANNELS*COMPONENTS];
  logic       reg_centered = 1'b0;
  logic [5:0] reg_wstart   = 6'd0;
  logic [5:0] reg_wlen     = 6'd32;
  logic [1:0] reg_ncomp    = 2'd3;
  logic [2:0] reg_nch      = 3'd4;

  out_item_t pending_features[$];
  row_t      plan[$];
  int        n_errors   = 0;
  int        burst_left = 0;
  bit        no_gaps    = 1'b0;
  bit        hold_req   = 1'b0;

  pca_waveform_feature_projection dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Hard stop in case the block hangs or loses a beat.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic in_item_t mk_beat(logic [1:0] act, int ch, int pos, int comp,
                                       int tv, int smp, bit last);
    in_item_t b;
    b.action      = act;
    b.channel     = ch[CH_W-1:0];
    b.position    = pos[POS_W-1:0];
    b.component   = comp[COMP_W-1:0];
    b.table_value = tv[TV_W-1:0];
    b.sample      = smp[SMP_W-1:0];
    b.last        = last;
    return b;
  endfunction

  // Fully random beat: any action, any field, used as noise between samples.
  function automatic in_item_t noise_beat();
    in_item_t b;
    b.action      = 2'($urandom);
    b.channel     = 2'($urandom);
    b.position    = 6'($urandom);
    b.component   = 2'($urandom);
    b.table_value = 24'($urandom);
    b.sample      = 16'($urandom);
    b.last        = 1'($urandom);
    return b;
  endfunction

  function automatic void add_beat(logic [1:0] act, int ch, int pos, int comp, int tv,
                                   int smp, bit last, bit zero_feat);
    row_t r;
    r.kind      = ROW_BEAT;
    r.beat      = mk_beat(act, ch, pos, comp, tv, smp, last);
    r.ridx      = '0;
    r.rval      = '0;
    r.zero_feat = zero_feat;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int val);
    row_t r;
    r.kind      = ROW_REG;
    r.beat      = '0;
    r.ridx      = idx;
    r.rval      = val[CFG_DATA_W-1:0];
    r.zero_feat = 1'b0;
    plan.push_back(r);
  endfunction

  // Predictor: applies one accepted beat to the shadow state and queues the
  // features it produces. Loads update the tables, samples in the window
  // accumulate, and a sample with last set dumps then clears the accumulators.
  task automatic project_beat(input in_item_t b, input bit zero_feat);
    int nch, ncomp, wlen, p, j, slot;
    longint x, prod, v, q;
    out_item_t r;
    nch   = clamp_count(int'(reg_nch), CHANNELS);
    ncomp = clamp_count(int'(reg_ncomp), COMPONENTS);
    wlen  = clamp_count(int'(reg_wlen), WINDOW);
    p     = int'(b.position);
    case (b.action)
      ACT_MEAN: begin
        if (p < WINDOW) mean_mem[int'(b.channel) * WINDOW + p] = b.table_value;
      end
      ACT_COEF: begin
        if (int'(b.component) < COMPONENTS && p < WINDOW) begin
          slot = (int'(b.channel) * COMPONENTS + int'(b.component)) * WINDOW + p;
          // wide coefficients clip to 16 bits
          if (b.table_value > 24'sd32767) coef_mem[slot] = 16'sh7fff;
          else if (b.table_value < -24'sd32768) coef_mem[slot] = 16'sh8000;
          else coef_mem[slot] = b.table_value[COEF_W-1:0];
        end
      end
      ACT_SAMPLE: begin
        j = p - int'(reg_wstart);
        if (p < SAMPLES && j >= 0 && j < wlen && int'(b.channel) < nch) begin
          x = longint'(b.sample) * 256;
          if (reg_centered) x = x - longint'(mean_mem[int'(b.channel) * WINDOW + j]);
          for (int k = 0; k < ncomp; k++) begin
            prod = x * longint'(coef_mem[(int'(b.channel) * COMPONENTS + k) * WINDOW + j]);
            // 48-bit accumulators wrap
            proj_acc[int'(b.channel) * COMPONENTS + k] =
              proj_acc[int'(b.channel) * COMPONENTS + k] + prod[ACC_W-1:0];
          end
        end
        if (b.last) begin
          for (int c = 0; c < nch; c++) begin
            for (int k = 0; k < ncomp; k++) begin
              v = longint'(proj_acc[c * COMPONENTS + k]);
              // round half away from zero, then saturate
              if (v >= 0) q = (v + HALF_LSB) >>> RND_SH;
              else q = -((-v + HALF_LSB) >>> RND_SH);
              if (q > 64'sd2147483647) q = 64'sd2147483647;
              if (q < -64'sd2147483648) q = -64'sd2147483648;
              r.feature       = zero_feat ? '0 : q[FEAT_W-1:0];
              r.feature_index = FIDX_W'(c * ncomp + k);
              r.run_end       = (c == nch - 1) && (k == ncomp - 1);
              pending_features.push_back(r);
            end
          end
          foreach (proj_acc[i]) proj_acc[i] = '0;
        end
      end
      default: ;  // unknown action: nothing happens
    endcase
  endtask

  // Offers one beat and holds it until accepted. Bursts of random length
  // are separated by random gaps unless no_gaps is set.
  task automatic put_beat(input in_item_t b, input bit zero_feat = 1'b0);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    project_beat(b, zero_feat);
  endtask

  // Drops valid, waits for every expected feature, then lets the pipe empty
  // of beats that produce nothing.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_features.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CENTERED:   reg_centered = val[0];
      CFG_WIN_START:  reg_wstart   = val;
      CFG_WIN_LENGTH: reg_wlen     = val;
      CFG_COMPONENTS: reg_ncomp    = val[1:0];
      CFG_CHANNELS:   reg_nch      = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int cen, input int ws, input int wl, input int cm,
                          input int chn);
    settle();
    write_reg(CFG_CENTERED,   CFG_DATA_W'(cen));
    write_reg(CFG_WIN_START,  CFG_DATA_W'(ws));
    write_reg(CFG_WIN_LENGTH, CFG_DATA_W'(wl));
    write_reg(CFG_COMPONENTS, CFG_DATA_W'(cm));
    write_reg(CFG_CHANNELS,   CFG_DATA_W'(chn));
  endtask

  // One waveform: n samples, mostly inside the window, the final one with
  // last set; random table loads and junk beats are mixed in.
  task automatic send_spike(input int n);
    int wl;
    in_item_t b;
    wl = clamp_count(int'(reg_wlen), WINDOW);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) put_beat(noise_beat());
      b.action      = ACT_SAMPLE;
      b.channel     = 2'($urandom);
      b.position    = ($urandom_range(0, 4) != 0) ?
                      6'(reg_wstart + $urandom_range(0, wl - 1)) : 6'($urandom);
      b.component   = 2'($urandom);
      b.table_value = 24'($urandom);
      b.sample      = ($urandom_range(0, 5) == 0) ?
                      ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) : 16'($urandom);
      b.last        = (i == n - 1);
      put_beat(b);
    end
  endtask

  // Result checker: every accepted feature beat against the oldest expectation.
  always @(posedge clk) begin : check_features
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_features.size() == 0) begin
        $error("feature beat with nothing expected: index %0d feature %0d",
               out_data.feature_index, out_data.feature);
        n_errors++;
      end else begin
        want = pending_features.pop_front();
        if (out_data.feature !== want.feature) begin
          $error("feature: expected %0d, got %0d", want.feature, out_data.feature);
          n_errors++;
        end
        if (out_data.feature_index !== want.feature_index) begin
          $error("feature_index: expected %0d, got %0d",
                 want.feature_index, out_data.feature_index);
          n_errors++;
        end
        if (out_data.run_end !== want.run_end) begin
          $error("run_end: expected %0d, got %0d", want.run_end, out_data.run_end);
          n_errors++;
        end
      end
    end
  end

  // Receiver: switches between stall patterns; on request it holds off for
  // a long stretch so the block backs up and stalls its input.
  initial begin : receiver
    int hold_left;
    int mode_left;
    rx_mode_e rx_mode;
    hold_left = 0;
    mode_left = 0;
    rx_mode   = RX_FREE;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          RX_TOGGLE: out_stall <= ~out_stall;
          default:   out_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin : stimulus
    int sent;
    int n;
    foreach (proj_acc[i]) proj_acc[i] = '0;

    // Directed plan. Only the first row has its features typed in: straight
    // after reset every accumulator is zero, and a closing sample outside the
    // window still dumps them.
    add_beat(ACT_SAMPLE, 0, 63, 0, 0, -32768, 1, 1);
    // table extremes and clipped coefficients
    add_beat(ACT_MEAN,   3, 31, 0,  8388607, 0, 0, 0);
    add_beat(ACT_MEAN,   0,  0, 0, -8388608, 0, 0, 0);
    add_beat(ACT_COEF,   3, 31, 2, -8388608, 0, 0, 0);
    add_beat(ACT_COEF,   0,  0, 0,  8388607, 0, 0, 0);
    // loads out of range, last on a load, unknown action: all ignored
    add_beat(ACT_COEF,   1,  5, 3,      123, 0, 1, 0);
    add_beat(ACT_MEAN,   2, 40, 0,       -5, 0, 1, 0);
    add_beat(ACT_COEF,   2, 63, 1,       77, 0, 0, 0);
    add_beat(ACT_NONE,   1,  7, 1,      999, 1234, 1, 0);
    // sample extremes, and products landing exactly on half an LSB
    add_beat(ACT_SAMPLE, 0,  0, 3, 0,  32767, 0, 0);
    add_beat(ACT_SAMPLE, 3, 31, 0, 0, -32768, 0, 0);
    add_beat(ACT_COEF,   1, 10, 0, 256, 0, 0, 0);
    add_beat(ACT_SAMPLE, 1, 10, 0, 0,     64, 0, 0);
    add_beat(ACT_COEF,   2, 11, 0, 256, 0, 0, 0);
    add_beat(ACT_SAMPLE, 2, 11, 0, 0,    -64, 1, 0);
    // centering against the extreme means
    add_reg(CFG_CENTERED, 1);
    add_beat(ACT_SAMPLE, 3, 31, 0, 0, -32768, 0, 0);
    add_beat(ACT_SAMPLE, 0,  0, 0, 0,  32767, 1, 0);
    // one channel, one component: samples on other channels add nothing
    add_reg(CFG_CHANNELS, 1);
    add_reg(CFG_COMPONENTS, 1);
    add_beat(ACT_SAMPLE, 2, 3, 0, 0,  1000, 0, 0);
    add_beat(ACT_SAMPLE, 0, 3, 0, 0, -1000, 1, 0);
    // counts above their range clamp, zero counts clamp to one
    add_reg(CFG_WIN_START, 63);
    add_reg(CFG_WIN_LENGTH, 63);
    add_reg(CFG_CHANNELS, 7);
    add_reg(CFG_COMPONENTS, 0);
    add_beat(ACT_SAMPLE, 1, 63, 0, 0, 500, 1, 0);
    add_reg(CFG_WIN_START, 5);
    add_reg(CFG_WIN_LENGTH, 0);
    add_beat(ACT_SAMPLE, 2, 6, 0, 0, -700, 0, 0);
    add_beat(ACT_SAMPLE, 2, 5, 0, 0,  700, 1, 0);
    add_reg(CFG_CENTERED, 0);
    add_reg(CFG_WIN_START, 0);
    add_reg(CFG_WIN_LENGTH, 32);
    add_reg(CFG_COMPONENTS, 3);
    add_reg(CFG_CHANNELS, 4);

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Tables have no reset value: fill every entry before any sample reads it.
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int pos = 0; pos < WINDOW; pos++) begin
        put_beat(mk_beat(ACT_MEAN, ch, pos, 0, int'($urandom), int'($urandom),
                         1'($urandom)));
        for (int k = 0; k < COMPONENTS; k++)
          put_beat(mk_beat(ACT_COEF, ch, pos, k,
                           ($urandom_range(0, 7) == 0) ? int'($urandom)
                                                       : int'(shortint'($urandom)),
                           int'($urandom), 1'($urandom)));
      end
    end

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].ridx, plan[i].rval);
      end else begin
        put_beat(plan[i].beat, plan[i].zero_feat);
      end
    end

    // Random waveforms under a fresh register setting per phase; window
    // starts are kept low most of the time so samples land inside.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) set_regs(1, 0, 32, 3, 4);
      else set_regs($urandom_range(0, 1),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, 8),
                    $urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 7));
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        n = $urandom_range(1, 8);
        send_spike(n);
        sent += n;
      end
    end

    // Back-pressure: the receiver holds off while one-sample waveforms,
    // each dumping twelve features, arrive back to back.
    set_regs(0, 0, 32, 3, 4);
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (PRESSURE_RUNS)
      put_beat(mk_beat(ACT_SAMPLE, $urandom_range(0, 3), $urandom_range(0, 31), 0, 0,
                       int'($urandom), 1'b1));
    no_gaps = 1'b0;

    // Accumulator wrap: the largest product added often enough to pass 2^47.
    set_regs(1, 0, 32, 1, 1);
    put_beat(mk_beat(ACT_MEAN, 0, 0, 0,  8388607, 0, 1'b0));
    put_beat(mk_beat(ACT_COEF, 0, 0, 0,   -32768, 0, 1'b0));
    for (int i = 0; i < WRAP_SAMPLES; i++)
      put_beat(mk_beat(ACT_SAMPLE, 0, 0, 0, 0, -32768, i == WRAP_SAMPLES - 1));

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pwfp_pkg.sv
hw/rtl/pwfp_tables.sv
hw/rtl/pwfp_mac.sv
hw/rtl/pwfp_drain.sv
hw/rtl/pca_waveform_feature_projection.sv
hw/rtl/pwfp_checker.sv
verif/testbench.sv
